[rtl/ptsb_pkg.sv]
`timescale 1ns / 1ps
// Shared sizes, codes and transfer types for the periodic timer slot bank.
// Used by ptsb_slot_store and periodic_timer_slot_bank; depends on nothing.
package ptsb_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int TICK_WIDTH = 32;
   localparam int TAG_WIDTH  = 16;

   localparam int SLOT_W   = $clog2(SLOT_COUNT);
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = ((2 * TICK_WIDTH + TAG_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELD_W = STATUS_W + SLOT_W + TAG_WIDTH;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic KIND_CREATE = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_HANDLER = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_SLOT    = 2'd2;

   typedef struct packed {
      logic                  write_all;
      logic                  write_expiry;
      logic [SLOT_W-1:0]     addr;
      logic [TICK_WIDTH-1:0] period;
      logic [TICK_WIDTH-1:0] expiry;
      logic [TAG_WIDTH-1:0]  tag;
   } slot_wr_type;

   typedef struct packed {
      logic [TICK_WIDTH-1:0] period;
      logic [TICK_WIDTH-1:0] expiry;
      logic [TAG_WIDTH-1:0]  tag;
   } slot_rd_type;

   typedef struct packed {
      logic                 kind;
      logic [STATUS_W-1:0]  status;
      logic [SLOT_W-1:0]    slot;
      logic [TAG_WIDTH-1:0] tag;
   } rsp_type;

endpackage

[rtl/ptsb_slot_store.sv]
`timescale 1ns / 1ps
// Per-slot period, expiry and tag memories: one write port, one registered read port.
// Depends on ptsb_pkg.
module ptsb_slot_store (
   input  logic                          clock,
   input  ptsb_pkg::slot_wr_type         wr_cmd,
   input  logic [ptsb_pkg::SLOT_W-1:0]   rd_addr,
   output ptsb_pkg::slot_rd_type         rd_data
);
   import ptsb_pkg::*;

   logic [TICK_WIDTH-1:0] period_mem [SLOT_COUNT];
   logic [TICK_WIDTH-1:0] expiry_mem [SLOT_COUNT];
   logic [TAG_WIDTH-1:0]  tag_mem    [SLOT_COUNT];
   slot_rd_type           rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_cmd.write_all) begin
         period_mem[wr_cmd.addr] <= wr_cmd.period;
         tag_mem[wr_cmd.addr]    <= wr_cmd.tag;
      end
      if (wr_cmd.write_all || wr_cmd.write_expiry) begin
         expiry_mem[wr_cmd.addr] <= wr_cmd.expiry;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff.period <= period_mem[rd_addr];
      rd_data_ff.expiry <= expiry_mem[rd_addr];
      rd_data_ff.tag    <= tag_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/periodic_timer_slot_bank.sv]
`timescale 1ns / 1ps
// Periodic timer slot bank: request decode, slot scan sequencer and result staging.
// Depends on ptsb_pkg and ptsb_slot_store.
//
// Usage:
//   req channel: req_tuser selects create, tick or clear; req_tdata carries
//   period, handler tag and current tick. req_tready is high only while the
//   sequencer is idle; one request is in flight at a time.
//   rsp channel: one transfer per create (tlast set), one per expired slot on
//   a tick (tlast on the final one), none for clear or an unused selector.
//   A create with a zero tag skips the scan and answers from the flush state;
//   otherwise create and tick walk the slots one per cycle, unless a stall
//   holds the scan, through a single compare/add unit and a memory port: a
//   tick walks every slot, a create stops at the first free slot, which it
//   claims, and a create that finds no slot walks them all.
//   Each found result is held one stage so tlast can be set once the scan
//   ends; the output register frees the sequencer while a result waits.
//   When rsp_tready stays low the scan halts on an expiring slot while a result
//   is held and the output register is full, until it drains; no result is dropped.
//   Reset clears all active flags, empties the output and returns to idle;
//   the memories are not cleared and their contents are used only for active slots.
module periodic_timer_slot_bank (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // period, handler_tag, tick_now
   input  logic [ptsb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // func
   input  logic [ptsb_pkg::FUNC_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, slot, fired_tag, zero pad
   output logic [ptsb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kind
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import ptsb_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PRIME = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [FUNC_W-1:0]     op_ff, op_in;
   logic [TICK_WIDTH-1:0] period_ff, period_in;
   logic [TAG_WIDTH-1:0]  tag_ff, tag_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   logic [SLOT_W-1:0]     eval_idx_ff, eval_idx_in;
   logic [SLOT_COUNT-1:0] slot_active_ff, slot_active_in;
   logic                  hold_valid_ff, hold_valid_in;
   rsp_type               hold_ff, hold_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;
   logic                  out_last_ff, out_last_in;

   slot_wr_type           wr_cmd;
   slot_rd_type           rd_data;
   logic [SLOT_W-1:0]     rd_addr;

   logic                  req_accept;
   logic                  out_free;
   logic                  scan_last;
   logic                  fire;
   logic                  stall;

   ptsb_slot_store u_store (
      .clock   (clock),
      .wr_cmd  (wr_cmd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign scan_last  = (eval_idx_ff == SLOT_W'(SLOT_COUNT - 1));
   assign fire       = (op_ff == FUNC_TICK) && slot_active_ff[eval_idx_ff]
                       && (tick_ff >= rd_data.expiry);
   assign stall      = (state_ff == ST_SCAN) && fire && hold_valid_ff && !out_free;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      period_in      = period_ff;
      tag_in         = tag_ff;
      tick_in        = tick_ff;
      eval_idx_in    = eval_idx_ff;
      slot_active_in = slot_active_ff;
      hold_valid_in  = hold_valid_ff;
      hold_in        = hold_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_in         = out_ff;
      out_last_in    = out_last_ff;
      wr_cmd         = '0;
      rd_addr        = eval_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in       = req_tuser;
               period_in   = req_tdata[TICK_WIDTH-1:0];
               tag_in      = req_tdata[TICK_WIDTH +: TAG_WIDTH];
               tick_in     = req_tdata[TICK_WIDTH + TAG_WIDTH +: TICK_WIDTH];
               eval_idx_in = '0;
               case (req_tuser)
                  FUNC_CREATE: begin
                     if (req_tdata[TICK_WIDTH +: TAG_WIDTH] == '0) begin
                        hold_in       = '{KIND_CREATE, STATUS_NO_HANDLER, '0, '0};
                        hold_valid_in = 1'b1;
                        state_in      = ST_FLUSH;
                     end else begin
                        state_in = ST_PRIME;
                     end
                  end
                  FUNC_TICK:  state_in = ST_PRIME;
                  FUNC_CLEAR: slot_active_in = '0;
                  default: ;
               endcase
            end
         end
         ST_PRIME: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (!stall) begin
               eval_idx_in = eval_idx_ff + SLOT_W'(1);
               rd_addr     = eval_idx_ff + SLOT_W'(1);
               if (op_ff == FUNC_CREATE) begin
                  if (!slot_active_ff[eval_idx_ff]) begin
                     wr_cmd.write_all            = 1'b1;
                     wr_cmd.addr                 = eval_idx_ff;
                     wr_cmd.period               = period_ff;
                     wr_cmd.expiry               = period_ff;
                     wr_cmd.tag                  = tag_ff;
                     slot_active_in[eval_idx_ff] = 1'b1;
                     hold_in       = '{KIND_CREATE, STATUS_OK, eval_idx_ff, '0};
                     hold_valid_in = 1'b1;
                     state_in      = ST_FLUSH;
                  end else if (scan_last) begin
                     hold_in       = '{KIND_CREATE, STATUS_NO_SLOT, '0, '0};
                     hold_valid_in = 1'b1;
                     state_in      = ST_FLUSH;
                  end
               end else begin
                  if (fire) begin
                     wr_cmd.write_expiry = 1'b1;
                     wr_cmd.addr         = eval_idx_ff;
                     wr_cmd.expiry       = tick_ff + rd_data.period;
                     if (hold_valid_ff) begin
                        out_valid_in = 1'b1;
                        out_in       = hold_ff;
                        out_last_in  = 1'b0;
                     end
                     hold_in       = '{KIND_EXPIRY, STATUS_OK, eval_idx_ff, rd_data.tag};
                     hold_valid_in = 1'b1;
                  end
                  if (scan_last) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_in        = hold_ff;
               out_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         slot_active_ff <= '0;
         hold_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         slot_active_ff <= slot_active_in;
         hold_valid_ff  <= hold_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      period_ff   <= period_in;
      tag_ff      <= tag_in;
      tick_ff     <= tick_in;
      eval_idx_ff <= eval_idx_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_ff.tag, out_ff.slot, out_ff.status});
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("staged result left behind in idle");

   a_prime_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRIME) |=> (eval_idx_ff == '0))
      else $error("scan does not start at slot zero");

   a_stall_holds_index: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(eval_idx_ff))
      else $error("scan advanced while stalled");

   a_write_read_apart: assert property (@(posedge clock) disable iff (reset)
      wr_cmd.write_expiry |-> (wr_cmd.addr != rd_addr))
      else $error("expiry write collides with prefetch read");

   a_create_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_CREATE)) |-> rsp_tlast)
      else $error("create response without tlast");
`endif

endmodule
